### hdl/hbs_pkg.sv
// Shared types, constants and register codes of the height brush stamp unit.
package hbs_pkg;

  localparam int MAX_SIDE         = 4096;
  localparam int HEIGHT_FRAC_BITS = 16;
  localparam int CNT_W            = 12;
  localparam int SIDE_W           = 13;
  localparam int POS_W            = 22;
  localparam int RAD_W            = 21;
  localparam int STR_W            = 17;
  localparam int HGT_W            = 24;
  localparam int ABS_W            = 22;
  localparam int D2_W             = 45;
  localparam int T_W              = 17;
  localparam int QUEUE_DEPTH      = 2;
  localparam int ADDR_W           = 5;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // Register indexes (paddr[4:2])
  localparam logic [2:0] REG_FIELD_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FIELD_HEIGHT = 3'd1;
  localparam logic [2:0] REG_CENTER_X     = 3'd2;
  localparam logic [2:0] REG_CENTER_Y     = 3'd3;
  localparam logic [2:0] REG_RADIUS       = 3'd4;
  localparam logic [2:0] REG_STRENGTH     = 3'd5;
  localparam logic [2:0] REG_FALLOFF_MODE = 3'd6;

  // Falloff modes
  localparam logic [1:0] FALL_CONST  = 2'd0;
  localparam logic [1:0] FALL_LINEAR = 2'd1;
  localparam logic [1:0] FALL_SMOOTH = 2'd2;
  localparam logic [1:0] FALL_ZERO   = 2'd3;

  typedef struct packed {
    logic signed [HGT_W-1:0] height_in;
    logic                    not_finite;
  } in_item_t;

  typedef struct packed {
    logic signed [HGT_W-1:0] height_out;
    logic                    touched;
    logic                    end_of_field;
  } out_item_t;

  typedef struct packed {
    logic signed [HGT_W-1:0] height;
    logic                    not_finite;
    logic [ABS_W-1:0]        adx;
    logic [ABS_W-1:0]        ady;
    logic                    end_of_field;
  } job_t;

  typedef struct packed {
    logic [SIDE_W-1:0]       field_width;
    logic [SIDE_W-1:0]       field_height;
    logic signed [POS_W-1:0] center_x;
    logic signed [POS_W-1:0] center_y;
    logic [RAD_W-1:0]        radius;
    logic signed [STR_W-1:0] strength;
    logic [1:0]              falloff_mode;
  } cfg_t;

  function automatic logic [CNT_W:0] sat_side(input logic [SIDE_W-1:0] v);
    logic [CNT_W:0] r;
    if (v < SIDE_W'(2)) r = (CNT_W+1)'(2);
    else if (v > SIDE_W'(MAX_SIDE)) r = (CNT_W+1)'(MAX_SIDE);
    else r = v;
    return r;
  endfunction

endpackage

### hdl/hbs_queue.sv
// Small register queue between the front and back parts.
module hbs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0]  mem_r [DEPTH];
  logic [PW-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]       cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != (PW+1)'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) wp_nxt = (wp_r == PW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
    if (do_pop)  rp_nxt = (rp_r == PW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_data;
  end
endmodule

### hdl/hbs_front.sv
// Front part: accept samples, track raster position, form brush offsets.
module hbs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hbs_pkg::in_item_t in_data,
  input  hbs_pkg::cfg_t     cfg,
  output logic              job_valid,
  input  logic              job_ready,
  output hbs_pkg::job_t     job
);
  import hbs_pkg::*;

  logic [CNT_W-1:0]  col_r, col_nxt, row_r, row_nxt;
  logic [CNT_W:0]    w, h;
  logic              last_col, last_row, take;
  logic signed [POS_W:0] dx, dy;

  assign w        = sat_side(cfg.field_width);
  assign h        = sat_side(cfg.field_height);
  assign last_col = ({1'b0, col_r} + 1'b1) >= w;
  assign last_row = ({1'b0, row_r} + 1'b1) >= h;
  assign in_ready  = job_ready;
  assign job_valid = in_valid;
  assign take      = in_valid && job_ready;

  assign dx = $signed({3'b000, col_r, 8'h00}) - (POS_W+1)'(cfg.center_x);
  assign dy = $signed({3'b000, row_r, 8'h00}) - (POS_W+1)'(cfg.center_y);

  always_comb begin
    job.height       = in_data.height_in;
    job.not_finite   = in_data.not_finite;
    job.adx          = dx[POS_W] ? ABS_W'(-dx) : ABS_W'(dx);
    job.ady          = dy[POS_W] ? ABS_W'(-dy) : ABS_W'(dy);
    job.end_of_field = last_col && last_row;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (take) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end
endmodule

### hdl/hbs_back.sv
// Back part: sequential distance, root, divide, falloff and blend unit.
module hbs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_ready,
  input  hbs_pkg::job_t      job,
  input  hbs_pkg::cfg_t      cfg,
  output logic               out_valid,
  input  logic               out_ready,
  output hbs_pkg::out_item_t out_data
);
  import hbs_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQX   = 4'd1;
  localparam logic [3:0] S_SQY   = 4'd2;
  localparam logic [3:0] S_RR    = 4'd3;
  localparam logic [3:0] S_CMP   = 4'd4;
  localparam logic [3:0] S_SQRT  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_FALL1 = 4'd7;
  localparam logic [3:0] S_FALL2 = 4'd8;
  localparam logic [3:0] S_SCALE = 4'd9;
  localparam logic [3:0] S_SUM   = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  localparam int SQ_W   = 42;
  localparam int SHIFT  = 31 - HEIGHT_FRAC_BITS;
  localparam int DM_W   = 34 - SHIFT;

  logic [3:0]        st_r, st_nxt;
  job_t              job_r;
  logic [D2_W-1:0]   d2_r;
  logic [SQ_W-1:0]   rr_r, v_r, res_r, bit_r;
  logic [RAD_W-1:0]  r_eff, rem_r;
  logic [T_W-1:0]    q_r;
  logic [3:0]        cnt_r;
  logic [16:0]       s_r, inf_r;
  logic [DM_W-1:0]   dm_r;
  logic              touched_r, outv_r;
  out_item_t         res_item_r, out_r;
  logic [SQ_W-1:0]   trial;
  logic [RAD_W:0]    rem2;
  logic [33:0]       t2, sm_prod, mg_prod;
  logic [17:0]       smul;
  logic [16:0]       mag, inf_c;
  logic signed [DM_W:0]    delta;
  logic signed [HGT_W+1:0] src, sum;
  logic [HGT_W-1:0]        clamped;
  logic                    load_out;

  assign r_eff   = (cfg.radius == '0) ? RAD_W'(1) : cfg.radius;
  assign trial   = res_r + bit_r;
  assign rem2    = {rem_r, 1'b0};
  assign t2      = 34'(q_r) * 34'(q_r);
  assign smul    = 18'd196608 - {q_r, 1'b0};
  assign sm_prod = 34'(s_r) * 34'(smul);
  assign mag     = cfg.strength[STR_W-1] ? 17'(-cfg.strength) : 17'(cfg.strength);
  assign mg_prod = 34'(mag) * 34'(inf_r);
  assign delta   = cfg.strength[STR_W-1] ? -$signed({1'b0, dm_r}) : $signed({1'b0, dm_r});
  assign src     = job_r.not_finite ? '0 : (HGT_W+2)'(job_r.height);
  assign sum     = src + (HGT_W+2)'(delta);
  assign clamped = sum[HGT_W+1] ? '0 :
                   (sum > (HGT_W+2)'(1 << HEIGHT_FRAC_BITS)) ?
                   HGT_W'(1 << HEIGHT_FRAC_BITS) : sum[HGT_W-1:0];

  always_comb begin
    unique case (cfg.falloff_mode)
      FALL_CONST:  inf_c = ONE_Q16;
      FALL_LINEAR: inf_c = ONE_Q16 - q_r;
      FALL_SMOOTH: inf_c = ONE_Q16 - sm_prod[32:16];
      default:     inf_c = '0;
    endcase
  end

  assign job_ready = (st_r == S_IDLE);
  assign load_out  = (st_r == S_DONE) && (!outv_r || out_ready);
  assign out_valid = outv_r;
  assign out_data  = out_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:  if (job_valid) st_nxt = S_SQX;
      S_SQX:   st_nxt = S_SQY;
      S_SQY:   st_nxt = S_RR;
      S_RR:    st_nxt = S_CMP;
      S_CMP:   st_nxt = (d2_r <= D2_W'(rr_r)) ? S_SQRT : S_DONE;
      S_SQRT:  if (bit_r[1:0] != 2'b00) st_nxt = S_DIV;
      S_DIV:   if (cnt_r == 4'd0) st_nxt = S_FALL1;
      S_FALL1: st_nxt = S_FALL2;
      S_FALL2: st_nxt = S_SCALE;
      S_SCALE: st_nxt = S_SUM;
      S_SUM:   st_nxt = S_DONE;
      S_DONE:  if (load_out) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      outv_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (load_out) outv_r <= 1'b1;
      else if (out_ready) outv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: if (job_valid) job_r <= job;
      S_SQX:  d2_r <= D2_W'(job_r.adx) * D2_W'(job_r.adx);
      S_SQY:  d2_r <= d2_r + D2_W'(job_r.ady) * D2_W'(job_r.ady);
      S_RR:   rr_r <= SQ_W'(r_eff) * SQ_W'(r_eff);
      S_CMP: begin
        v_r        <= d2_r[SQ_W-1:0];
        res_r      <= '0;
        bit_r      <= SQ_W'(1) << 40;
        touched_r  <= (d2_r <= D2_W'(rr_r));
        res_item_r <= '{height_out: job_r.height, touched: 1'b0,
                        end_of_field: job_r.end_of_field};
      end
      S_SQRT: begin
        // One result bit per cycle; the last step seeds the divider.
        if (v_r >= trial) begin
          v_r   <= v_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r[1:0] != 2'b00) begin
          if (v_r >= trial) begin
            rem_r <= ((res_r >> 1) + bit_r) >= SQ_W'(r_eff) ?
                     RAD_W'(((res_r >> 1) + bit_r) - SQ_W'(r_eff)) :
                     RAD_W'((res_r >> 1) + bit_r);
            q_r   <= T_W'(((res_r >> 1) + bit_r) >= SQ_W'(r_eff));
          end else begin
            rem_r <= RAD_W'(res_r >> 1) >= r_eff ? RAD_W'(res_r >> 1) - r_eff
                                                 : RAD_W'(res_r >> 1);
            q_r   <= T_W'(RAD_W'(res_r >> 1) >= r_eff);
          end
          cnt_r <= 4'd15;
        end
      end
      S_DIV: begin
        if (rem2 >= {1'b0, r_eff}) begin
          rem_r <= RAD_W'(rem2 - {1'b0, r_eff});
          q_r   <= {q_r[T_W-2:0], 1'b1};
        end else begin
          rem_r <= rem2[RAD_W-1:0];
          q_r   <= {q_r[T_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
      end
      S_FALL1: s_r   <= t2[32:16];
      S_FALL2: inf_r <= inf_c;
      S_SCALE: dm_r  <= mg_prod[33:SHIFT];
      S_SUM: res_item_r <= '{height_out: clamped, touched: touched_r,
                             end_of_field: job_r.end_of_field};
      S_DONE: if (load_out) out_r <= res_item_r;
      default: ;
    endcase
  end
endmodule

### hdl/height_brush_stamp_unit.sv
// Top level of the height brush stamp unit: config registers, front, queue, back.
// The unit takes a height field in raster order, one sample per item, and
// counts column and row itself against the configured field size. Each sample
// is tested against a round brush (center and radius in Q13.8); samples
// outside pass through untouched, samples inside get source plus strength
// times falloff influence, clamped to 0..1.0 in Q7.16. The front takes an item
// per cycle, while the two-entry queue has room; the back works through each
// item in a shared sequential unit; a sample inside the radius also passes the
// 21-step square root and the divider that forms the 17-bit quotient. The result
// sits in an output register, so the queue keeps filling while a result waits.
// Configuration goes through the APB port (registers at 4*index); the user is to
// write it only while the unit is idle, which the block itself does not enforce.
module height_brush_stamp_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  hbs_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output hbs_pkg::out_item_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hbs_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import hbs_pkg::*;

  cfg_t       cfg_r;
  logic [2:0] idx;
  logic       wr_en;
  logic       fj_valid, fj_ready, bj_valid, bj_ready;
  job_t       fj, bj;

  // Register file: always ready, write on the access phase.
  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.field_width  <= SIDE_W'(256);
      cfg_r.field_height <= SIDE_W'(256);
      cfg_r.center_x     <= '0;
      cfg_r.center_y     <= '0;
      cfg_r.radius       <= RAD_W'(256);
      cfg_r.strength     <= '0;
      cfg_r.falloff_mode <= FALL_CONST;
    end else if (wr_en) begin
      priority case (idx)
        REG_FIELD_WIDTH:  cfg_r.field_width  <= pwdata[SIDE_W-1:0];
        REG_FIELD_HEIGHT: cfg_r.field_height <= pwdata[SIDE_W-1:0];
        REG_CENTER_X:     cfg_r.center_x     <= pwdata[POS_W-1:0];
        REG_CENTER_Y:     cfg_r.center_y     <= pwdata[POS_W-1:0];
        REG_RADIUS:       cfg_r.radius       <= pwdata[RAD_W-1:0];
        REG_STRENGTH:     cfg_r.strength     <= pwdata[STR_W-1:0];
        REG_FALLOFF_MODE: cfg_r.falloff_mode <= pwdata[1:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // Read back, zero padded.
  always_comb begin
    priority case (idx)
      REG_FIELD_WIDTH:  prdata = 32'(cfg_r.field_width);
      REG_FIELD_HEIGHT: prdata = 32'(cfg_r.field_height);
      REG_CENTER_X:     prdata = 32'(unsigned'(cfg_r.center_x));
      REG_CENTER_Y:     prdata = 32'(unsigned'(cfg_r.center_y));
      REG_RADIUS:       prdata = 32'(cfg_r.radius);
      REG_STRENGTH:     prdata = 32'(unsigned'(cfg_r.strength));
      REG_FALLOFF_MODE: prdata = 32'(cfg_r.falloff_mode);
      default:          prdata = '0;
    endcase
  end

  // Front: raster position and brush offsets for each accepted item.
  hbs_front u_front (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_data,
    .cfg       (cfg_r),
    .job_valid (fj_valid),
    .job_ready (fj_ready),
    .job       (fj)
  );

  // Queue: decouple intake from the slow back part.
  hbs_queue #(.WIDTH($bits(job_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n,
    .push_valid (fj_valid),
    .push_ready (fj_ready),
    .push_data  (fj),
    .pop_valid  (bj_valid),
    .pop_ready  (bj_ready),
    .pop_data   (bj)
  );

  // Back: distance test, falloff and blend, one item at a time.
  hbs_back u_back (
    .clk, .rst_n,
    .job_valid (bj_valid),
    .job_ready (bj_ready),
    .job       (bj),
    .cfg       (cfg_r),
    .out_valid, .out_ready, .out_data
  );
endmodule

### hdl/hbs_checker.sv
// Port-level checker for the height brush stamp unit, bound to the top level.
module hbs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input hbs_pkg::out_item_t out_data
);
  import hbs_pkg::*;

  // Results are gone after reset.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set right after reset");

  // A touched sample always lands inside the clamp range.
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.touched |->
      !out_data.height_out[HGT_W-1] &&
      (out_data.height_out <= HGT_W'(1 << HEIGHT_FRAC_BITS)))
    else $error("touched height outside clamp range");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
endmodule

bind height_brush_stamp_unit hbs_checker u_hbs_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_data
);

### verif/tb.sv
// Self-checking testbench for the height brush stamp unit.
`timescale 1ns / 100ps

module tb;
  import hbs_pkg::*;

  localparam int ITEMS_PER_PHASE = 150;
  localparam int N_PHASES        = 10;
  localparam int SETTLE_CYCLES   = 200;  // covers the queue and the back end going idle

  // Directed stimulus row: item plus an optional expectation typed in by hand
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t result;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      psel;
  logic      penable;
  logic      pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic      pready;

  // Mirror of the configuration and raster position
  logic [SIDE_W-1:0]       mir_width;
  logic [SIDE_W-1:0]       mir_height;
  logic signed [POS_W-1:0] mir_cx;
  logic signed [POS_W-1:0] mir_cy;
  logic [RAD_W-1:0]        mir_radius;
  logic signed [STR_W-1:0] mir_strength;
  logic [1:0]              mir_mode;
  logic [CNT_W-1:0]        col_pos;
  logic [CNT_W-1:0]        row_pos;

  out_item_t pending_heights[$];
  int        fail_count;
  bit        calm;        // stretches without any idling on either side
  int        cycle_count;

  height_brush_stamp_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #8ms;
    $display("Some tests failed");
    $finish;
  end

  // Count cycles and flip between calm and noisy stretches
  initial begin
    cycle_count = 0;
    calm = 1'b0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count % 400 == 0) calm = ($urandom_range(0, 3) == 0);
    end
  end

  function automatic int side_clip(logic [SIDE_W-1:0] v);
    if (v < 2) return 2;
    if (v > MAX_SIDE) return MAX_SIDE;
    return int'(v);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Compute the stamped sample for the current raster position, then advance it
  function automatic out_item_t stamp_sample(in_item_t it);
    out_item_t o;
    longint w, h, r, dx, dy, d2, d, t, s, inf, src, mag, dm, delta, sum, top;
    bit last_col, last_row;
    w = side_clip(mir_width);
    h = side_clip(mir_height);
    r = (mir_radius == 0) ? 1 : longint'(mir_radius);
    dx = longint'(col_pos) * 256 - longint'(mir_cx);
    dy = longint'(row_pos) * 256 - longint'(mir_cy);
    d2 = dx * dx + dy * dy;
    last_col = (longint'(col_pos) + 1 >= w);
    last_row = (longint'(row_pos) + 1 >= h);
    top = longint'(1) << HEIGHT_FRAC_BITS;
    o.height_out = it.height_in;
    o.touched = 1'b0;
    o.end_of_field = last_col && last_row;
    if (d2 <= r * r) begin
      d = longint'(root_floor(d2));
      t = (d << 16) / r;
      if (t > 65536) t = 65536;
      case (mir_mode)
        FALL_CONST:  inf = 65536;
        FALL_LINEAR: inf = 65536 - t;
        FALL_SMOOTH: begin
          s = (t * t) >> 16;
          inf = 65536 - ((s * (196608 - 2 * t)) >> 16);
        end
        default:     inf = 0;
      endcase
      src = it.not_finite ? 0 : longint'($signed(it.height_in));
      mag = (mir_strength < 0) ? -longint'(mir_strength) : longint'(mir_strength);
      dm = (mag * inf) >> (31 - HEIGHT_FRAC_BITS);
      delta = (mir_strength < 0) ? -dm : dm;
      sum = src + delta;
      if (sum < 0) sum = 0;
      if (sum > top) sum = top;
      o.height_out = sum[HGT_W-1:0];
      o.touched = 1'b1;
    end
    if (last_col) begin
      col_pos = '0;
      row_pos = last_row ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    return o;
  endfunction

  // APB write: setup phase, access phase, then the bus parked before returning
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_FIELD_WIDTH:  mir_width    = value[SIDE_W-1:0];
      REG_FIELD_HEIGHT: mir_height   = value[SIDE_W-1:0];
      REG_CENTER_X:     mir_cx       = value[POS_W-1:0];
      REG_CENTER_Y:     mir_cy       = value[POS_W-1:0];
      REG_RADIUS:       mir_radius   = value[RAD_W-1:0];
      REG_STRENGTH:     mir_strength = value[STR_W-1:0];
      default:          mir_mode     = value[1:0];
    endcase
    @(posedge clk);
  endtask

  task automatic program_brush(logic [31:0] w, logic [31:0] h, logic [31:0] cx,
                               logic [31:0] cy, logic [31:0] r, logic [31:0] st,
                               logic [31:0] mode);
    write_reg(REG_FIELD_WIDTH, w);
    write_reg(REG_FIELD_HEIGHT, h);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_RADIUS, r);
    write_reg(REG_STRENGTH, st);
    write_reg(REG_FALLOFF_MODE, mode);
  endtask

  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(15, 70);
  endfunction

  // Offer one item after an optional gap; hold it until accepted, then predict.
  // Valid is only lowered when a gap follows, so it never drops and rises in one step.
  task automatic offer_item(in_item_t it, bit typed, out_item_t typed_res);
    int gap;
    out_item_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    res = stamp_sample(it);
    pending_heights.push_back(typed ? typed_res : res);
  endtask

  // Let every expected result drain, then give the back end time to go idle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t random_sample();
    in_item_t it;
    case ($urandom_range(0, 4))
      0: it.height_in = HGT_W'($urandom);
      1: it.height_in = HGT_W'($urandom_range(0, 65536));
      2: it.height_in = -$signed(HGT_W'($urandom_range(0, 70000)));
      3: it.height_in = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      default: it.height_in = HGT_W'($urandom_range(60000, 70000));
    endcase
    it.not_finite = ($urandom_range(0, 7) == 0);
    return it;
  endfunction

  // Receiver: random stalls, calm stretches, and one long hold-off to fill the unit
  initial begin
    int hold;
    int roll;
    bit pressed;
    out_ready <= 1'b0;
    hold = 0;
    pressed = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (!pressed && cycle_count > 6000 && in_valid) begin
        pressed = 1'b1;
        hold = 400;
        out_ready <= 1'b0;
      end else begin
        roll = $urandom_range(0, 99);
        if (!calm && roll < 12) begin
          hold = (roll < 2) ? $urandom_range(20, 80) : $urandom_range(0, 3);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Check each accepted result against the oldest expectation
  initial begin
    out_item_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_heights.size() == 0) begin
          $error("result with nothing expected: height_out %0d", $signed(out_data.height_out));
          fail_count++;
        end else begin
          want = pending_heights.pop_front();
          if (out_data.height_out !== want.height_out) begin
            $error("height_out expected %0d actual %0d",
                   $signed(want.height_out), $signed(out_data.height_out));
            fail_count++;
          end
          if (out_data.touched !== want.touched) begin
            $error("touched expected %0b actual %0b", want.touched, out_data.touched);
            fail_count++;
          end
          if (out_data.end_of_field !== want.end_of_field) begin
            $error("end_of_field expected %0b actual %0b",
                   want.end_of_field, out_data.end_of_field);
            fail_count++;
          end
        end
      end
    end
  end

  // Main sequence
  initial begin
    stim_row_t rows[12];
    out_item_t none;
    logic [31:0] w, h, cx, cy, r, st, mode;
    int span;
    fail_count = 0;
    none = '0;
    rst_n   <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    mir_width = 256; mir_height = 256; mir_cx = 0; mir_cy = 0;
    mir_radius = 256; mir_strength = 0; mir_mode = FALL_CONST;
    col_pos = '0; row_pos = '0;

    // Reset brush: center at origin, radius one column, zero strength.
    // Column 0 and 1 are inside, so the source is only clamped; the rest pass through.
    rows[0]  = '{'{24'h7FFFFF, 1'b0}, 1'b1, '{24'd65536, 1'b1, 1'b0}};
    rows[1]  = '{'{24'h800000, 1'b0}, 1'b1, '{24'd0, 1'b1, 1'b0}};
    rows[2]  = '{'{24'h123456, 1'b1}, 1'b1, '{24'h123456, 1'b0, 1'b0}};
    rows[3]  = '{'{24'h7FFFFF, 1'b1}, 1'b1, '{24'h7FFFFF, 1'b0, 1'b0}};
    rows[4]  = '{'{24'h800000, 1'b0}, 1'b1, '{24'h800000, 1'b0, 1'b0}};
    rows[5]  = '{'{24'hAAAAAA, 1'b0}, 1'b0, none};
    rows[6]  = '{'{24'h555555, 1'b1}, 1'b0, none};
    rows[7]  = '{'{24'h000000, 1'b0}, 1'b0, none};
    rows[8]  = '{'{24'hFFFFFF, 1'b0}, 1'b0, none};
    rows[9]  = '{'{24'h010000, 1'b0}, 1'b0, none};
    rows[10] = '{'{24'h00FFFF, 1'b1}, 1'b0, none};
    rows[11] = '{'{24'h010001, 1'b0}, 1'b0, none};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) offer_item(rows[i].item, rows[i].typed, rows[i].result);
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        // Sides below range, zero radius, strength of plus one
        0: program_brush(0, 1, 0, 0, 0, 32768, FALL_CONST);
        // Sides above range, far center, widest radius, strength of minus one
        1: program_brush(8191, 8191, 32'h200000, 32'h200000, 32'h1FFFFF, 32'h18000,
                         FALL_LINEAR);
        // Strength beyond one (raw bits), center at top of range, zero influence
        2: program_brush(3, 2, 32'h1FFFFF, 32'h100, 32'h1FFFFF, 32'h0FFFF, FALL_ZERO);
        // Size lowered mid-field: counters past the new last column wrap on the next sample
        3: program_brush(2, 2, 128, 128, 200, 32'h1FFFF, FALL_SMOOTH);
        default: begin
          w = $urandom_range(0, 9) == 0 ? $urandom_range(0, 8191) : $urandom_range(2, 24);
          h = $urandom_range(2, 24);
          span = side_clip(w[SIDE_W-1:0]) * 256;
          if (span > 24 * 256) span = 24 * 256;
          cx = $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, span) - 512;
          cy = $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, h * 256) - 512;
          r = $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 14 * 256);
          st = $urandom;
          mode = $urandom;
          program_brush(w, h, cx, cy, r, st, mode);
        end
      endcase
      for (int k = 0; k < ITEMS_PER_PHASE; k++) offer_item(random_sample(), 1'b0, none);
      drain();
    end

    if (pending_heights.size() != 0) begin
      $error("%0d expected results never arrived", pending_heights.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
